### rtl/fmcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmcd_pkg
// Shared constants, types and decode helpers for the framed motor command
// decoder.
// ----------------------------------------------------------------------------
package fmcd_pkg;

  // Receive position wraps at this depth (17 .. 256)
  localparam int unsigned BufDepth = 128;
  localparam int unsigned PosW     = $clog2(BufDepth);

  // Only frame bytes 0 .. 16 are ever read
  localparam int unsigned FrameLen = 17;
  localparam int unsigned NumChan  = 4;
  localparam int unsigned NumCmp   = 2 * NumChan;
  localparam int unsigned CmpW     = 16;

  // Character codes
  localparam logic [7:0] CharStart = 8'h3C;  // '<'
  localparam logic [7:0] CharEnd   = 8'h3E;  // '>'
  localparam logic [7:0] CharMotor = 8'h4D;  // 'M'
  localparam logic [7:0] CharVolt  = 8'h56;  // 'V'
  localparam logic [7:0] CharDirA  = 8'h41;  // 'A'
  localparam logic [7:0] CharDirB  = 8'h42;  // 'B'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'

  localparam logic [CmpW-1:0] WeightHundreds = 16'd100;
  localparam logic [CmpW-1:0] WeightTens     = 16'd10;

  // Result kind codes
  typedef enum logic {
    KIND_MOTOR = 1'b0,
    KIND_VOLT  = 1'b1
  } kind_e;

  typedef logic [FrameLen-1:0][7:0] frame_t;

  // One result transaction
  typedef struct packed {
    kind_e                     kind;
    logic [NumCmp-1:0][CmpW-1:0] cmp;
  } result_t;

  // Three ASCII digits to a value, modulo 2^16, no digit checks
  function automatic logic [CmpW-1:0] decode_digits(input logic [7:0] d0,
                                                    input logic [7:0] d1,
                                                    input logic [7:0] d2);
    logic [CmpW-1:0] v0;
    logic [CmpW-1:0] v1;
    logic [CmpW-1:0] v2;
    logic [CmpW-1:0] p0;
    logic [CmpW-1:0] p1;
    v0 = CmpW'(d0) - CmpW'(CharZero);
    v1 = CmpW'(d1) - CmpW'(CharZero);
    v2 = CmpW'(d2) - CmpW'(CharZero);
    p0 = v0 * WeightHundreds;
    p1 = v1 * WeightTens;
    return p0 + p1 + v2;
  endfunction

endpackage
`default_nettype wire

### rtl/fmcd_frame_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmcd_frame_store
// Frame byte store and write position. Start bytes rewind the position,
// end bytes leave the store alone, all other bytes are kept when they land
// in the first FrameLen positions.
// ----------------------------------------------------------------------------
module fmcd_frame_store
  import fmcd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_en_i,
  input  wire logic [7:0] byte_i,
  output frame_t          frame_o
);

  frame_t          frame_q, frame_d;
  logic [PosW-1:0] pos_q, pos_d;

  // Update store and position for one byte
  always_comb begin
    frame_d = frame_q;
    pos_d   = pos_q;
    if (wr_en_i) begin
      if (byte_i == CharStart) begin
        pos_d = '0;
      end else if (byte_i != CharEnd) begin
        for (int unsigned i = 0; i < FrameLen; i++) begin
          if (pos_q == PosW'(i)) begin
            frame_d[i] = byte_i;
          end
        end
        if (pos_q == PosW'(BufDepth - 1)) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      pos_q   <= '0;
    end else begin
      frame_q <= frame_d;
      pos_q   <= pos_d;
    end
  end

  assign frame_o = frame_q;

endmodule
`default_nettype wire

### rtl/fmcd_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmcd_decoder
// Frame decode on an end byte: motor compare update or voltage request.
// ----------------------------------------------------------------------------
module fmcd_decoder
  import fmcd_pkg::*;
(
  input  wire logic       is_end_i,
  input  wire frame_t     frame_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  logic [NumChan-1:0][CmpW-1:0] value;
  logic [NumChan-1:0]           dir_a;
  logic [NumChan-1:0]           dir_b;

  // Decode each channel: direction byte then three digits
  always_comb begin
    for (int unsigned m = 0; m < NumChan; m++) begin
      dir_a[m] = (frame_i[1 + 4*m] == CharDirA);
      dir_b[m] = (frame_i[1 + 4*m] == CharDirB);
      value[m] = decode_digits(frame_i[2 + 4*m], frame_i[3 + 4*m], frame_i[4 + 4*m]);
    end
  end

  // Route values to compare slots; second timer has A and B swapped
  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    if (is_end_i && frame_i[0] == CharMotor) begin
      res_valid_o = 1'b1;
      res_o.kind  = KIND_MOTOR;
      res_o.cmp[0] = dir_a[0] ? value[0] : '0;
      res_o.cmp[1] = dir_b[0] ? value[0] : '0;
      res_o.cmp[2] = dir_a[1] ? value[1] : '0;
      res_o.cmp[3] = dir_b[1] ? value[1] : '0;
      res_o.cmp[4] = dir_b[2] ? value[2] : '0;
      res_o.cmp[5] = dir_a[2] ? value[2] : '0;
      res_o.cmp[6] = dir_b[3] ? value[3] : '0;
      res_o.cmp[7] = dir_a[3] ? value[3] : '0;
    end else if (is_end_i && frame_i[0] == CharVolt) begin
      res_valid_o = 1'b1;
      res_o.kind  = KIND_VOLT;
    end
  end

endmodule
`default_nettype wire

### rtl/framed_motor_command_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_motor_command_decoder
// An end byte's result passes through the input register, then the result
// register. Throughput: one byte per cycle, set by the store update and
// decode between the two registers; an end byte that yields a result waits
// in the input register while an earlier result is held.
// Reset clears the frame store, the write position and both valid flags.
// ----------------------------------------------------------------------------
module framed_motor_command_decoder
  import fmcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [15:0]      cmp_a1_o,
  output logic [15:0]      cmp_b1_o,
  output logic [15:0]      cmp_a2_o,
  output logic [15:0]      cmp_b2_o,
  output logic [15:0]      cmp_b3_o,
  output logic [15:0]      cmp_a3_o,
  output logic [15:0]      cmp_b4_o,
  output logic [15:0]      cmp_a4_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  result_t    res_q;

  frame_t     frame;
  logic       res_valid;
  result_t    res;
  logic       advance;

  // Retire the held byte unless its result would collide with a stalled one
  assign advance    = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  fmcd_frame_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (advance),
    .byte_i  (byte_q),
    .frame_o (frame)
  );

  fmcd_decoder u_decoder (
    .is_end_i    (in_valid_q && byte_q == CharEnd),
    .frame_i     (frame),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register: load a new result, drop a delivered one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign cmp_a1_o    = res_q.cmp[0];
  assign cmp_b1_o    = res_q.cmp[1];
  assign cmp_a2_o    = res_q.cmp[2];
  assign cmp_b2_o    = res_q.cmp[3];
  assign cmp_b3_o    = res_q.cmp[4];
  assign cmp_a3_o    = res_q.cmp[5];
  assign cmp_b4_o    = res_q.cmp[6];
  assign cmp_a4_o    = res_q.cmp[7];

endmodule
`default_nettype wire

### sim/fmcd_frame_checker.sv
// ----------------------------------------------------------------------------
// fmcd_frame_checker
// Watches both channels of the framed motor command decoder. Keeps its own
// copy of the frame store and write position, updates it with every accepted
// byte, queues the command that a frame end should produce, and compares
// each delivered result field by field against the oldest pending command.
// ----------------------------------------------------------------------------
module fmcd_frame_checker
  import fmcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        kind_i,
  input  wire logic [15:0] cmp_a1_i,
  input  wire logic [15:0] cmp_b1_i,
  input  wire logic [15:0] cmp_a2_i,
  input  wire logic [15:0] cmp_b2_i,
  input  wire logic [15:0] cmp_b3_i,
  input  wire logic [15:0] cmp_a3_i,
  input  wire logic [15:0] cmp_b4_i,
  input  wire logic [15:0] cmp_a4_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               motor_seen_o,
  output int               volt_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Output order of the compare fields, index 0 first
  localparam string CmpName [NumCmp] = '{"cmp_a1", "cmp_b1", "cmp_a2", "cmp_b2",
                                         "cmp_b3", "cmp_a3", "cmp_b4", "cmp_a4"};

  logic [7:0]  frame_copy [FrameLen];
  int unsigned wr_pos;
  result_t     pending_cmds [$];
  int          fail_count  = 0;
  int          pending_n   = 0;
  int          motor_seen  = 0;
  int          volt_seen   = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_n;
  assign motor_seen_o = motor_seen;
  assign volt_seen_o  = volt_seen;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_count++;
  endtask

  // Three ASCII digits, weights 100/10/1, wrapped to 16 bits
  function automatic logic [CmpW-1:0] digits_value(input logic [7:0] d0,
                                                   input logic [7:0] d1,
                                                   input logic [7:0] d2);
    int acc;
    acc = (int'(d0) - int'(CharZero)) * 100 + (int'(d1) - int'(CharZero)) * 10
        + (int'(d2) - int'(CharZero));
    return acc[CmpW-1:0];
  endfunction

  // Update the frame store and queue the command a frame end produces
  task automatic absorb_byte(input logic [7:0] b);
    result_t         cmd;
    logic [7:0]      dir;
    logic [CmpW-1:0] val;
    int              a_idx;
    int              b_idx;
    if (b == CharStart) begin
      wr_pos = 0;
    end else if (b != CharEnd) begin
      if (wr_pos < FrameLen) frame_copy[wr_pos] = b;
      wr_pos = (wr_pos + 1) % BufDepth;
    end else if (frame_copy[0] == CharMotor) begin
      cmd      = '0;
      cmd.kind = KIND_MOTOR;
      for (int m = 0; m < NumChan; m++) begin
        dir = frame_copy[1 + 4 * m];
        val = digits_value(frame_copy[2 + 4 * m], frame_copy[3 + 4 * m],
                           frame_copy[4 + 4 * m]);
        // second timer has its A/B channel pair swapped
        a_idx = (m < 2) ? 2 * m : 2 * m + 1;
        b_idx = (m < 2) ? 2 * m + 1 : 2 * m;
        if (dir == CharDirA) cmd.cmp[a_idx] = val;
        if (dir == CharDirB) cmd.cmp[b_idx] = val;
      end
      pending_cmds.push_back(cmd);
    end else if (frame_copy[0] == CharVolt) begin
      cmd      = '0;
      cmd.kind = KIND_VOLT;
      pending_cmds.push_back(cmd);
    end
  endtask

  // Compare one delivered result with the oldest pending command
  task automatic check_result();
    result_t got;
    result_t want;
    got.kind   = kind_e'(kind_i);
    got.cmp[0] = cmp_a1_i;
    got.cmp[1] = cmp_b1_i;
    got.cmp[2] = cmp_a2_i;
    got.cmp[3] = cmp_b2_i;
    got.cmp[4] = cmp_b3_i;
    got.cmp[5] = cmp_a3_i;
    got.cmp[6] = cmp_b4_i;
    got.cmp[7] = cmp_a4_i;
    if (got.kind == KIND_VOLT) volt_seen++;
    else motor_seen++;
    if (pending_cmds.size() == 0) begin
      report_mismatch($sformatf("result with no pending command, kind %0d", got.kind));
    end else begin
      want = pending_cmds.pop_front();
      if (got.kind != want.kind)
        report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
      for (int i = 0; i < NumCmp; i++) begin
        if (got.cmp[i] !== want.cmp[i])
          report_mismatch($sformatf("%s got %0d want %0d", CmpName[i],
                                    got.cmp[i], want.cmp[i]));
      end
    end
  endtask

  // Track both channels; results leave before bytes of the same edge enter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FrameLen; i++) frame_copy[i] = '0;
      wr_pos = 0;
      pending_cmds.delete();
      pending_n <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) absorb_byte(rx_byte_i);
      pending_n <= pending_cmds.size();
    end
  end

endmodule

### sim/tb_framed_motor_command_decoder.sv
// ----------------------------------------------------------------------------
// tb_framed_motor_command_decoder
// Feeds the decoder directed bytes and then random motor, voltage, short,
// long and noise frames under four idle/stall mixes and one long output
// hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_framed_motor_command_decoder;
  import fmcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TargetItems = 1750;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic        kind;
  logic [15:0] cmp_a1, cmp_b1, cmp_a2, cmp_b2, cmp_b3, cmp_a3, cmp_b4, cmp_a4;

  int   fail_count;
  int   pending;
  int   motor_seen;
  int   volt_seen;
  int   sent_items     = 0;
  int   cycles         = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_off       = 1'b0;

  framed_motor_command_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .kind_o      (kind),
    .cmp_a1_o    (cmp_a1),
    .cmp_b1_o    (cmp_b1),
    .cmp_a2_o    (cmp_a2),
    .cmp_b2_o    (cmp_b2),
    .cmp_b3_o    (cmp_b3),
    .cmp_a3_o    (cmp_a3),
    .cmp_b4_o    (cmp_b4),
    .cmp_a4_o    (cmp_a4)
  );

  fmcd_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .kind_i       (kind),
    .cmp_a1_i     (cmp_a1),
    .cmp_b1_i     (cmp_b1),
    .cmp_a2_i     (cmp_a2),
    .cmp_b2_i     (cmp_b2),
    .cmp_b3_i     (cmp_b3),
    .cmp_a3_i     (cmp_a3),
    .cmp_b4_i     (cmp_b4),
    .cmp_a4_i     (cmp_a4),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .motor_seen_o (motor_seen),
    .volt_seen_o  (volt_seen)
  );

  // Generate the clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d commands pending", cycles, pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Drive the result side: random stalls, forced low during a hold-off
  initial begin
    forever begin
      @(posedge clk);
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold off the result side for a long stretch once requested
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  // Any byte except the two delimiters
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CharStart || b == CharEnd) b = 8'($urandom_range(255));
    return b;
  endfunction

  // Mostly a decimal digit, sometimes anything else
  function automatic logic [7:0] digit_byte();
    if ($urandom_range(99) < 85) return CharZero + 8'($urandom_range(9));
    return payload_byte();
  endfunction

  // Mostly A or B, sometimes anything else
  function automatic logic [7:0] dir_byte();
    if ($urandom_range(99) < 85) return $urandom_range(1) ? CharDirA : CharDirB;
    return payload_byte();
  endfunction

  // Send one random frame or a burst of noise
  task automatic send_random_frame();
    int         sel;
    int         n;
    logic [7:0] lead;
    sel = $urandom_range(99);
    if (sel < 55) begin
      // well-formed motor command
      send_byte(CharStart);
      send_byte(CharMotor);
      for (int m = 0; m < NumChan; m++) begin
        send_byte(dir_byte());
        for (int d = 0; d < 3; d++) send_byte(digit_byte());
      end
      send_byte(CharEnd);
    end else if (sel < 70) begin
      // voltage request with a little trailing payload
      send_byte(CharStart);
      send_byte(CharVolt);
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) send_byte(payload_byte());
      send_byte(CharEnd);
    end else if (sel < 88) begin
      // short or long frame; short ones decode stale bytes
      case ($urandom_range(2))
        0:       lead = CharMotor;
        1:       lead = CharVolt;
        default: lead = payload_byte();
      endcase
      if (sel < 80) n = $urandom_range(6);
      else if ($urandom_range(19) == 0) n = $urandom_range(140, 130);
      else n = $urandom_range(30, 17);
      send_byte(CharStart);
      send_byte(lead);
      for (int i = 0; i < n; i++) send_byte($urandom_range(1) ? digit_byte() : dir_byte());
      send_byte(CharEnd);
    end else begin
      // raw noise, sometimes closed by an end with no start
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
      if ($urandom_range(1)) send_byte(CharEnd);
    end
  endtask

  // Reset, directed bytes, random phases, drain and verdict
  initial begin
    logic [7:0] directed [$];
    int         phase_end;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end with no start on a cleared store, byte extremes, voltage request,
    // then a motor frame with a non-digit channel and a channel with no direction
    directed = {CharEnd, 8'h00, 8'hFF, CharStart, CharVolt, CharEnd,
                CharStart, CharMotor, CharDirA, "9", "9", "9", CharDirB, "0", "0", "0",
                CharDirB, 8'hFF, 8'h00, "9", "C", "1", "2", "3", CharEnd};
    foreach (directed[i]) send_byte(directed[i]);

    // idle mixes: none, sender idle, receiver stall, both lightly
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req      <= 1'b1;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      phase_end = sent_items + (TargetItems - sent_items) / (4 - phase);
      while (sent_items < phase_end) send_random_frame();
    end

    // drain outstanding commands
    in_valid       <= 1'b0;
    recv_stall_pct  = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d bytes: directed cases plus motor, voltage, short, long and noise frames",
             sent_items);
    $display("over four idle/stall mixes and a long hold-off; checked %0d motor and %0d voltage",
             motor_seen, volt_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/fmcd_pkg.sv
rtl/fmcd_frame_store.sv
rtl/fmcd_decoder.sv
rtl/framed_motor_command_decoder.sv
sim/fmcd_frame_checker.sv
sim/tb_framed_motor_command_decoder.sv
